FILE: sv/odometry_range_bearing_unit_macros.svh
// assertion macros for the odometry range and bearing unit
// used by the top level, which provides clk and rst in scope
`ifndef ODOMETRY_RANGE_BEARING_UNIT_MACROS_SVH
`define ODOMETRY_RANGE_BEARING_UNIT_MACROS_SVH

// property that must hold at every edge out of reset
`define ORB_ASSERT_HOLD(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("orb assertion failed");

// implication checked at every edge out of reset
`define ORB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("orb assertion failed");

`endif

FILE: sv/orb_pkg.sv
// shared constants, types and the arctangent table of the odometry unit
// no dependencies
package orb_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_COUNT = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int GAIN_BITS = 24;
  localparam logic [GAIN_BITS-1:0] GAIN_INV = 24'd10188015;
  localparam int GUARD = 8;
  localparam int DW = 36;   // cordic datapath width
  localparam int ZW = 34;   // cordic angle width, 2^32 per turn
  localparam int RW = 28;   // width of an ungained result
  localparam int AW = 61;   // serial multiplier accumulator
  localparam logic [24:0] RANGE_MAX = 25'd23726566;
  localparam int DEG_MAX = 11520;
  localparam logic signed [23:0] GOAL_X_RESET = 24'sd714342;
  localparam logic signed [23:0] GOAL_Y_RESET = -24'sd244449;

  localparam logic [1:0] KIND_OWN = 2'd0;
  localparam logic [1:0] KIND_PEER = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic CFG_GOAL_X = 1'b0;
  localparam logic CFG_GOAL_Y = 1'b1;

  typedef struct packed {
    logic start;
    logic vectoring;
  } orb_cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
  } orb_stat_t;

  function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      5'd0:  a = 34'sh020000000;
      5'd1:  a = 34'sh012E4051E;
      5'd2:  a = 34'sh009FB385B;
      5'd3:  a = 34'sh0051111D4;
      5'd4:  a = 34'sh0028B0D43;
      5'd5:  a = 34'sh00145D7E1;
      5'd6:  a = 34'sh000A2F61E;
      5'd7:  a = 34'sh000517C55;
      5'd8:  a = 34'sh00028BE53;
      5'd9:  a = 34'sh000145F2F;
      5'd10: a = 34'sh0000A2F98;
      5'd11: a = 34'sh0000517CC;
      5'd12: a = 34'sh000028BE6;
      5'd13: a = 34'sh0000145F3;
      5'd14: a = 34'sh00000A2F9;
      5'd15: a = 34'sh00000517D;
      5'd16: a = 34'sh0000028BE;
      5'd17: a = 34'sh00000145F;
      5'd18: a = 34'sh000000A30;
      5'd19: a = 34'sh000000518;
      5'd20: a = 34'sh00000028C;
      5'd21: a = 34'sh000000146;
      5'd22: a = 34'sh0000000A3;
      5'd23: a = 34'sh000000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/orb_if.sv
// valid/ready channel interfaces for pose input and range/bearing output
// depends on orb_pkg
interface orb_in_if;
  import orb_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [23:0] x_coord;
  logic signed [23:0] y_coord;
  logic signed [15:0] heading;
  modport source (output valid, kind, x_coord, y_coord, heading, input ready);
  modport sink (input valid, kind, x_coord, y_coord, heading, output ready);
endinterface

interface orb_out_if;
  import orb_pkg::*;
  logic valid;
  logic ready;
  logic [24:0] goal_range;
  logic signed [14:0] goal_bearing;
  logic [24:0] peer_range;
  logic signed [14:0] peer_bearing;
  modport source (output valid, goal_range, goal_bearing, peer_range, peer_bearing,
                  input ready);
  modport sink (input valid, goal_range, goal_bearing, peer_range, peer_bearing,
                output ready);
endinterface

FILE: sv/orb_cordic.sv
// iterative cordic, one micro-rotation a cycle, then a bit-serial gain correction
// depends on orb_pkg
module orb_cordic (
  input  logic clk,
  input  logic rst,
  input  orb_pkg::orb_cmd_t cmd,
  input  logic signed [orb_pkg::DW-1:0] x0,
  input  logic signed [orb_pkg::DW-1:0] y0,
  input  logic signed [orb_pkg::ZW-1:0] z0,
  output orb_pkg::orb_stat_t stat,
  output logic signed [orb_pkg::RW-1:0] x_res,
  output logic signed [orb_pkg::RW-1:0] y_res,
  output logic signed [orb_pkg::ZW-1:0] z_res
);
  import orb_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_ITER = 2'd1;
  localparam logic [1:0] P_MUL = 2'd2;

  logic [1:0] phase;
  logic [4:0] cnt;
  logic vec;
  logic done;
  logic signed [DW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic signed [AW-1:0] acc_x, acc_y;
  logic signed [DW-1:0] xs, ys;
  logic ccw;
  logic signed [ZW-1:0] fold_hi, fold_lo;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign ccw = vec ? y[DW-1] : ~z[ZW-1];
  assign fold_hi = ZW'(64'sd1 <<< 30);
  assign fold_lo = -fold_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt <= '0;
      done <= 1'b0;
      vec <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (cmd.start) begin
            phase <= P_ITER;
            cnt <= '0;
            vec <= cmd.vectoring;
          end
        end
        P_ITER: begin
          if (cnt == 5'(STEP_COUNT - 1)) begin
            phase <= P_MUL;
            cnt <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        P_MUL: begin
          if (cnt == 5'(GAIN_BITS - 1)) begin
            phase <= P_IDLE;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (phase == P_IDLE && cmd.start) begin
      if (cmd.vectoring) begin
        if (x0[DW-1]) begin
          x <= -x0;
          y <= -y0;
          z <= y0[DW-1] ? -ZW'(64'sd1 <<< 31) : ZW'(64'sd1 <<< 31);
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end else if (z0 > fold_hi) begin
        x <= -x0;
        y <= -y0;
        z <= z0 - ZW'(64'sd1 <<< 31);
      end else if (z0 < fold_lo) begin
        x <= -x0;
        y <= -y0;
        z <= z0 + ZW'(64'sd1 <<< 31);
      end else begin
        x <= x0;
        y <= y0;
        z <= z0;
      end
    end else if (phase == P_ITER) begin
      if (ccw) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_at(cnt);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_at(cnt);
      end
      if (cnt == 5'(STEP_COUNT - 1)) begin
        acc_x <= AW'(64'sd1 <<< 31);
        acc_y <= AW'(64'sd1 <<< 31);
      end
    end else if (phase == P_MUL) begin
      if (GAIN_INV[cnt]) begin
        acc_x <= acc_x + (AW'(x) <<< cnt);
        acc_y <= acc_y + (AW'(y) <<< cnt);
      end
    end
  end

  assign stat.done = done;
  assign stat.busy = (phase != P_IDLE);
  assign x_res = RW'(acc_x >>> 32);
  assign y_res = RW'(acc_y >>> 32);
  assign z_res = z;

endmodule

FILE: sv/odometry_range_bearing_unit.sv
// odometry range and bearing unit, top level
// depends on orb_pkg, orb_if, orb_cordic and odometry_range_bearing_unit_macros.svh
//
// A pose transaction of kind 0 stores robot one's pose, kind 1 stores robot
// two's position and kind 3 is dropped. A tick (kind 2) rotates robot one's
// displacement since the previous tick by its current heading, adds it to the
// saturating dead-reckoned estimate, and then measures range and bearing from
// the goal and from robot two to the estimate. All three passes share one
// cordic: 16 micro-rotations plus a bit-serial gain correction over the 24
// gain bits each; the sequencer sees each pass done, then starts the next.
// The result is loaded once the previous one is taken, and input is taken
// again the cycle after (a zero difference vector skips its pass). Input is
// not taken while a tick is at work; a finished result sits in the output
// register and poses keep flowing meanwhile, but the next tick stalls before
// delivery until that result is taken. The user must write goal registers
// only while idle; the block itself does not enforce it.
`include "odometry_range_bearing_unit_macros.svh"

module odometry_range_bearing_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [23:0] cfg_data,
  orb_in_if.sink in_ch,
  orb_out_if.source out_ch
);
  import orb_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT = 3'd1;
  localparam logic [2:0] S_GSTART = 3'd2;
  localparam logic [2:0] S_GWAIT = 3'd3;
  localparam logic [2:0] S_PSTART = 3'd4;
  localparam logic [2:0] S_PWAIT = 3'd5;
  localparam logic [2:0] S_HOLD = 3'd6;

  logic [2:0] state;
  logic signed [23:0] goal_x, goal_y;
  logic signed [23:0] own_x, own_y, own_x_prev, own_y_prev;
  logic signed [15:0] own_hdg;
  logic signed [23:0] est_x, est_y, peer_x, peer_y;
  logic [24:0] g_rng, p_rng;
  logic signed [14:0] g_brg, p_brg;

  orb_cmd_t cmd;
  orb_stat_t stat;
  logic signed [DW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;
  logic signed [RW-1:0] x_res, y_res;
  logic signed [ZW-1:0] z_res;

  logic accept;
  logic load_out;
  logic signed [24:0] dx, dy, ex, ey;
  logic signed [28:0] sum_x, sum_y;
  logic signed [40:0] z_wide, deg_full;
  logic signed [17:0] deg;
  logic [24:0] rng_sat;
  logic signed [14:0] brg_sat;

  assign in_ch.ready = (state == S_IDLE);
  assign accept = in_ch.valid & in_ch.ready;

  // output register takes the result once the previous one is gone
  assign load_out = (state == S_HOLD) && (!out_ch.valid || out_ch.ready);

  // displacement since the previous tick
  assign dx = 25'(own_x) - 25'(own_x_prev);
  assign dy = 25'(own_y) - 25'(own_y_prev);

  // difference vector for the pass about to start
  always_comb begin
    if (state == S_GSTART) begin
      ex = 25'(est_x) - 25'(goal_x);
      ey = 25'(est_y) - 25'(goal_y);
    end else begin
      ex = 25'(est_x) - 25'(peer_x);
      ey = 25'(est_y) - 25'(peer_y);
    end
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.vectoring = 1'b1;
    x0 = DW'(ex) <<< GUARD;
    y0 = DW'(ey) <<< GUARD;
    z0 = ZW'(own_hdg) <<< 16;
    if (accept && in_ch.kind == KIND_TICK) begin
      cmd.start = 1'b1;
      cmd.vectoring = 1'b0;
      x0 = DW'(dx) <<< GUARD;
      y0 = DW'(dy) <<< GUARD;
    end else if ((state == S_GSTART || state == S_PSTART) && (ex != '0 || ey != '0)) begin
      cmd.start = 1'b1;
    end
  end

  orb_cordic u_cordic (
    .clk(clk), .rst(rst), .cmd(cmd), .x0(x0), .y0(y0), .z0(z0),
    .stat(stat), .x_res(x_res), .y_res(y_res), .z_res(z_res)
  );

  // estimate update with saturation to 24 bits
  assign sum_x = 29'(est_x) + 29'(x_res);
  assign sum_y = 29'(est_y) + 29'(y_res);

  // range saturation and bearing in 1/64 degree units, z * 45 / 2^23 rounded half up
  assign z_wide = 41'(z_res);
  assign deg_full = (z_wide <<< 5) + (z_wide <<< 3) + (z_wide <<< 2) + z_wide
                    + 41'(64'sd1 <<< 22);
  assign deg = 18'(deg_full >>> 23);
  assign rng_sat = x_res[RW-1] ? '0 :
                   (x_res > $signed({3'b000, RANGE_MAX}) ? RANGE_MAX : 25'(x_res));
  assign brg_sat = (deg > 18'(DEG_MAX)) ? 15'(DEG_MAX) :
                   (deg < -18'(DEG_MAX)) ? -15'(DEG_MAX) : 15'(deg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      goal_x <= GOAL_X_RESET;
      goal_y <= GOAL_Y_RESET;
      own_x <= '0;
      own_y <= '0;
      own_hdg <= '0;
      own_x_prev <= '0;
      own_y_prev <= '0;
      est_x <= '0;
      est_y <= '0;
      peer_x <= '0;
      peer_y <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GOAL_X: goal_x <= cfg_data;
          CFG_GOAL_Y: goal_y <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_ch.kind)
              KIND_OWN: begin
                own_x <= in_ch.x_coord;
                own_y <= in_ch.y_coord;
                own_hdg <= in_ch.heading;
              end
              KIND_PEER: begin
                peer_x <= in_ch.x_coord;
                peer_y <= in_ch.y_coord;
              end
              KIND_TICK: begin
                own_x_prev <= own_x;
                own_y_prev <= own_y;
                state <= S_ROT;
              end
              default: ;
            endcase
          end
        end
        S_ROT: begin
          if (stat.done) begin
            est_x <= (sum_x > 29'sd8388607) ? 24'sh7FFFFF :
                     (sum_x < -29'sd8388608) ? 24'sh800000 : 24'(sum_x);
            est_y <= (sum_y > 29'sd8388607) ? 24'sh7FFFFF :
                     (sum_y < -29'sd8388608) ? 24'sh800000 : 24'(sum_y);
            state <= S_GSTART;
          end
        end
        S_GSTART: begin
          if (cmd.start) begin
            state <= S_GWAIT;
          end else begin
            g_rng <= '0;
            g_brg <= '0;
            state <= S_PSTART;
          end
        end
        S_GWAIT: begin
          if (stat.done) begin
            g_rng <= rng_sat;
            g_brg <= brg_sat;
            state <= S_PSTART;
          end
        end
        S_PSTART: begin
          if (cmd.start) begin
            state <= S_PWAIT;
          end else begin
            p_rng <= '0;
            p_brg <= '0;
            state <= S_HOLD;
          end
        end
        S_PWAIT: begin
          if (stat.done) begin
            p_rng <= rng_sat;
            p_brg <= brg_sat;
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          // load the output register once the previous result is gone
          if (load_out) begin
            out_ch.goal_range <= g_rng;
            out_ch.goal_bearing <= g_brg;
            out_ch.peer_range <= p_rng;
            out_ch.peer_bearing <= p_brg;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // cordic finishes only while the sequencer waits on it
  `ORB_ASSERT_IMP(a_done_in_wait, stat.done,
    state == S_ROT || state == S_GWAIT || state == S_PWAIT)
  // a new result appears only out of the hold step
  `ORB_ASSERT_IMP(a_out_from_hold, $rose(out_ch.valid), $past(state) == S_HOLD)
  // the cordic is never started while busy
  `ORB_ASSERT_HOLD(a_no_restart, !(cmd.start && stat.busy))

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the odometry range and bearing unit
// depends on orb_pkg, orb_if and the odometry_range_bearing_unit top level
// predicts each tick's range and bearing fix in fixed point and checks every output transaction
`timescale 1ns / 100ps

module tb_top;
  import orb_pkg::*;

  // gain correction and arctangent table, angles in units of 2^32 per turn
  localparam longint GAIN_MUL = 64'sd10188015;
  localparam longint TURN_TABLE [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };
  localparam longint POS_MAX = 64'sd8388607;
  localparam longint POS_MIN = -64'sd8388608;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [24:0] goal_range;
    logic signed [14:0] goal_bearing;
    logic [24:0] peer_range;
    logic signed [14:0] peer_bearing;
  } fix_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [23:0] cfg_data;

  orb_in_if in_ch ();
  orb_out_if out_ch ();

  odometry_range_bearing_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // shadow of the block's state
  longint goal_x, goal_y;
  longint own_x, own_y, own_hdg, last_x, last_y;
  longint track_x, track_y, robot2_x, robot2_y;

  fix_t pending_fixes[$];
  int errors;
  int quiet_cycles;
  bit steady;       // when set, neither side idles
  longint walk_x, walk_y;   // last pose sent for robot one

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // drop cordic gain and guard bits, round half up
  function automatic longint drop_gain(longint v);
    return (v * GAIN_MUL + 64'sd2147483648) >>> 32;
  endfunction

  // rotation mode: turn (dx, dy) by a binary angle
  task automatic turn_vector(input longint dx, input longint dy, input longint ang,
                             output longint rx, output longint ry);
    longint x, y, z, xs, ys;
    x = dx <<< GUARD;
    y = dy <<< GUARD;
    z = ang * 65536;
    // beyond a quarter turn, negate the vector and fold the angle
    if (z > (64'sd1 <<< 30)) begin
      x = -x; y = -y; z = z - (64'sd1 <<< 31);
    end else if (z < -(64'sd1 <<< 30)) begin
      x = -x; y = -y; z = z + (64'sd1 <<< 31);
    end
    for (int i = 0; i < STEP_COUNT; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - TURN_TABLE[i];
      end else begin
        x = x + ys; y = y - xs; z = z + TURN_TABLE[i];
      end
    end
    rx = drop_gain(x);
    ry = drop_gain(y);
  endtask

  // vectoring mode: range and bearing in 1/64 degree units of (ex, ey)
  task automatic range_bearing(input longint ex, input longint ey,
                               output logic [24:0] rng, output logic signed [14:0] brg);
    longint x, y, z, xs, ys;
    x = ex <<< GUARD;
    y = ey <<< GUARD;
    z = 0;
    if (ex == 0 && ey == 0) begin
      // zero difference: both reported as zero
      rng = '0;
      brg = '0;
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
        x = -x; y = -y;
      end
      for (int i = 0; i < STEP_COUNT; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + TURN_TABLE[i];
        end else begin
          x = x - ys; y = y + xs; z = z - TURN_TABLE[i];
        end
      end
      rng = 25'(sat(drop_gain(x), 0, longint'(RANGE_MAX)));
      brg = 15'(sat((z * 45 + (64'sd1 <<< 22)) >>> 23, -DEG_MAX, DEG_MAX));
    end
  endtask

  // apply one accepted input transaction to the shadow state
  task automatic predict_item(input logic [1:0] kind, input longint px, input longint py,
                              input longint ph);
    longint lx, ly;
    fix_t f;
    if (kind == KIND_OWN) begin
      own_x = px; own_y = py; own_hdg = ph;
    end else if (kind == KIND_PEER) begin
      // robot two's heading is ignored
      robot2_x = px; robot2_y = py;
    end else if (kind == KIND_TICK) begin
      turn_vector(own_x - last_x, own_y - last_y, own_hdg, lx, ly);
      track_x = sat(track_x + lx, POS_MIN, POS_MAX);
      track_y = sat(track_y + ly, POS_MIN, POS_MAX);
      range_bearing(track_x - goal_x, track_y - goal_y, f.goal_range, f.goal_bearing);
      range_bearing(track_x - robot2_x, track_y - robot2_y, f.peer_range, f.peer_bearing);
      last_x = own_x;
      last_y = own_y;
      pending_fixes.push_back(f);
    end
    // kind 3 does nothing
  endtask

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one pose or tick transaction and update the prediction on acceptance
  task automatic send_item(input logic [1:0] kind, input longint px, input longint py,
                           input longint ph);
    int gap;
    logic signed [23:0] wx, wy;
    logic signed [15:0] wh;
    // fields wrap to their port widths
    wx = 24'(px);
    wy = 24'(py);
    wh = 16'(ph);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.x_coord <= wx;
    in_ch.y_coord <= wy;
    in_ch.heading <= wh;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(kind, longint'(wx), longint'(wy), longint'(wh));
    if (kind == KIND_OWN) begin
      walk_x = longint'(wx); walk_y = longint'(wy);
    end
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_fixes.size() != 0) @(posedge clk);
    // a margin after the last fix; a pose takes effect when it is accepted
    repeat (20) @(posedge clk);
  endtask

  // goal register write, only while idle
  task automatic write_goal(input logic idx, input longint val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 24'(val);
    @(posedge clk);
    if (idx == CFG_GOAL_X) goal_x = val;
    else goal_y = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random back pressure and checking
  // ---------------------------------------------------------------------------

  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (steady) begin
        out_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold = hold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 9) < 3) hold = ($urandom_range(0, 9) == 0) ?
                                              $urandom_range(10, 50) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    fix_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_fixes.size() == 0) begin
        $error("fix transaction with nothing expected");
        errors++;
      end else begin
        want = pending_fixes.pop_front();
        if (out_ch.goal_range !== want.goal_range) begin
          $error("goal_range expected %0d got %0d", want.goal_range, out_ch.goal_range);
          errors++;
        end
        if (out_ch.goal_bearing !== want.goal_bearing) begin
          $error("goal_bearing expected %0d got %0d", want.goal_bearing, out_ch.goal_bearing);
          errors++;
        end
        if (out_ch.peer_range !== want.peer_range) begin
          $error("peer_range expected %0d got %0d", want.peer_range, out_ch.peer_range);
          errors++;
        end
        if (out_ch.peer_bearing !== want.peer_bearing) begin
          $error("peer_bearing expected %0d got %0d", want.peer_bearing, out_ch.peer_bearing);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transaction while work is outstanding
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (!in_ch.valid && pending_fixes.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero vectors, kind 3, field extremes, estimate and range saturation
  task automatic test_directed();
    steady = 1'b1;
    send_item(KIND_TICK, 0, 0, 0);                 // estimate and robot two both at origin
    send_item(2'd3, POS_MAX, POS_MIN, -32768);     // unused kind
    send_item(KIND_TICK, 0, 0, 0);
    send_item(KIND_OWN, 65536, 0, 0);
    send_item(KIND_TICK, 0, 0, 0);
    send_item(KIND_OWN, 65536, 65536, 16384);      // quarter turn
    send_item(KIND_TICK, 0, 0, 0);
    send_item(KIND_OWN, 0, 0, 32767);              // near half turn, folded
    send_item(KIND_TICK, 0, 0, 0);
    send_item(KIND_OWN, POS_MAX, POS_MAX, -32768);
    send_item(KIND_PEER, POS_MIN, POS_MAX, 32767);  // peer heading ignored
    send_item(KIND_TICK, 0, 0, 0);
    send_item(KIND_OWN, POS_MIN, POS_MIN, -16384);
    send_item(KIND_TICK, 0, 0, 0);                 // drives estimate into saturation
    send_item(KIND_OWN, POS_MAX, POS_MIN, 0);
    send_item(KIND_TICK, 0, 0, 0);
    send_item(KIND_PEER, POS_MAX, POS_MIN, -1);
    send_item(KIND_TICK, 0, 0, 0);                 // peer at the estimate or far away
    send_item(KIND_OWN, POS_MAX, POS_MIN, -32768);
    send_item(KIND_TICK, 0, 0, 0);                 // no movement
    steady = 1'b0;
  endtask

  // goal at extremes and at the estimate, which gives a zero goal vector
  task automatic test_goal_settings();
    write_goal(CFG_GOAL_X, POS_MIN);
    write_goal(CFG_GOAL_Y, POS_MAX);
    send_item(KIND_TICK, 0, 0, 0);
    write_goal(CFG_GOAL_X, POS_MAX);
    write_goal(CFG_GOAL_Y, POS_MIN);
    send_item(KIND_TICK, 0, 0, 0);
    write_goal(CFG_GOAL_X, track_x);
    write_goal(CFG_GOAL_Y, track_y);
    send_item(KIND_TICK, 0, 0, 0);
    write_goal(CFG_GOAL_X, 0);
    write_goal(CFG_GOAL_Y, 0);
    send_item(KIND_OWN, 0, 0, 0);
    send_item(KIND_TICK, 0, 0, 0);
  endtask

  // mostly small robot one steps between ticks, with noise and wild poses
  task automatic run_random(input int count);
    int r;
    longint s;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      s = (r % 5 == 0) ? 64'sd1048576 : 64'sd65536;
      if (r < 30) begin
        send_item(KIND_TICK, $signed(24'($urandom)), $signed(24'($urandom)),
                  $signed(16'($urandom)));
      end else if (r < 65) begin
        send_item(KIND_OWN,
                  sat(walk_x + longint'($urandom_range(0, 2 * s)) - s, POS_MIN, POS_MAX),
                  sat(walk_y + longint'($urandom_range(0, 2 * s)) - s, POS_MIN, POS_MAX),
                  $signed(16'($urandom)));
      end else if (r < 80) begin
        send_item(KIND_PEER, track_x + longint'($urandom_range(0, 2000000)) - 1000000,
                  track_y + longint'($urandom_range(0, 2000000)) - 1000000,
                  $signed(16'($urandom)));
      end else if (r < 88) begin
        send_item(KIND_PEER, $signed(24'($urandom)), $signed(24'($urandom)),
                  $signed(16'($urandom)));
      end else if (r < 95) begin
        send_item(KIND_OWN, $signed(24'($urandom)), $signed(24'($urandom)),
                  $signed(16'($urandom)));
      end else begin
        send_item(2'd3, $signed(24'($urandom)), $signed(24'($urandom)),
                  $signed(16'($urandom)));
      end
      // new goal settings now and then, written only while idle
      if (n % 200 == 199) begin
        write_goal(CFG_GOAL_X, $signed(24'($urandom)));
        write_goal(CFG_GOAL_Y, $signed(24'($urandom)));
      end
    end
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    goal_x = longint'(GOAL_X_RESET);
    goal_y = longint'(GOAL_Y_RESET);
    own_x = 0; own_y = 0; own_hdg = 0; last_x = 0; last_y = 0;
    track_x = 0; track_y = 0; robot2_x = 0; robot2_y = 0;
    walk_x = 0; walk_y = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_GOAL_X;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_OWN;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.heading = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_goal_settings();
    run_random(600);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_fixes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: odometry_range_bearing_unit.f
+incdir+sv
sv/orb_pkg.sv
sv/orb_if.sv
sv/orb_cordic.sv
sv/odometry_range_bearing_unit.sv
bench/tb_top.sv
